[hdl/ris_pkg.sv]
// ris_pkg: shared types and constants for the inlier scoring unit
// no dependencies
package ris_pkg;
  localparam int WordW = 48;
  localparam int PixW = 32;
  localparam int CntW = 13;
  localparam int SumW = 44;
  localparam int HypW = 4;
  localparam int MaxHypotheses = 16;
  localparam int ProdW = 96;
  localparam int AccW = 99;
  localparam int DivW = 123;
  localparam int QlimW = 41;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [PixW-1:0] ThreshReset = 32'd1678;
  localparam int InW = 2 + 4 + WordW;
  localparam int FeatW = 2 * PixW + 3 * WordW;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_FEATURE = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUB, ST_MUL, ST_ACC, ST_CHECK, ST_DIVX_START, ST_DIVX_WAIT,
    ST_DIVY_START, ST_DIVY_WAIT, ST_ERR, ST_SQ, ST_SCORE, ST_OUT
  } state_t;

  typedef struct packed {
    logic       load_item;
    logic       do_load;
    logic       do_close;
    logic       do_clear;
    logic       do_sub;
    logic [1:0] mul_step;
    logic [1:0] mul_part;
    logic       do_mul;
    logic       do_acc;
    logic       clr_acc;
    logic       div_start;
    logic       div_sel_y;
    logic       take_x;
    logic       take_y;
    logic       do_err;
    logic       do_sq;
    logic       do_score;
    logic       zero_score;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       depth_zero;
    logic       div_done;
  } status_t;
endpackage

[hdl/ris_divider.sv]
// ris_divider: shared restoring divider, one quotient bit per cycle
// depends on ris_pkg
module ris_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [ris_pkg::DivW-1:0] dividend,
  input  logic [ris_pkg::AccW-1:0] divisor,
  output logic done,
  output logic [ris_pkg::DivW-1:0] quotient
);
  import ris_pkg::*;
  logic [DivW-1:0] quo;
  logic [AccW:0] rem;
  logic [AccW-1:0] dvs;
  logic [6:0] cnt;
  logic busy;
  logic [AccW:0] shifted;
  logic [AccW+1:0] diff;

  assign shifted = {rem[AccW-1:0], quo[DivW-1]};
  assign diff = {1'b0, shifted} - {2'b00, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'(DivW);
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
      end else if (busy) begin
        if (!diff[AccW+1]) begin
          rem <= diff[AccW:0];
          quo <= {quo[DivW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[DivW-2:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[hdl/ris_datapath.sv]
// ris_datapath: pose store, projection arithmetic, scoring and output register
// depends on ris_pkg, ris_divider
module ris_datapath (
  input  logic clk,
  input  logic rst,
  input  ris_pkg::cmd_t cmd,
  output ris_pkg::status_t status,
  input  logic [ris_pkg::InW-1:0] in_pose,
  input  logic [ris_pkg::FeatW-1:0] in_feat,
  input  logic [1:0] in_kind,
  input  logic cfg_we,
  input  logic [ris_pkg::PixW-1:0] cfg_data,
  output logic [151:0] out_data
);
  import ris_pkg::*;
  logic [WordW-1:0] pose [12];
  logic [1:0] kind;
  logic [3:0] widx;
  logic [WordW-1:0] wval;
  logic signed [PixW-1:0] px, py;
  logic signed [WordW-1:0] pt [3];
  logic signed [WordW:0] t [3];
  logic signed [ProdW:0] prod [3];
  logic signed [AccW-1:0] nx, ny, nz;
  logic [PixW-1:0] thresh;
  logic signed [QlimW:0] qx, qy;
  logic [QlimW+1:0] ux, uy;
  logic ovf;
  logic [2*28:0] sq_sum;
  logic [PixW-1:0] err;
  logic inl, zd;
  logic [CntW-1:0] run_cnt, best_cnt;
  logic [SumW-1:0] run_sum, best_sum;
  logic [HypW-1:0] hyp, best_num;
  logic div_done;
  logic [DivW-1:0] div_q;
  logic signed [AccW-1:0] num_sel;
  logic [AccW-1:0] num_mag, den_mag;
  logic neg_sel;
  logic signed [QlimW:0] qs;
  logic [SumW:0] sum_add;
  logic [PixW-1:0] score_err;
  logic score_inl;

  assign status.kind = kind;
  assign status.depth_zero = (nz == '0);
  assign status.div_done = div_done;

  assign num_sel = cmd.div_sel_y ? ny : nx;
  assign num_mag = num_sel[AccW-1] ? AccW'(-num_sel) : num_sel;
  assign den_mag = nz[AccW-1] ? AccW'(-nz) : nz;
  assign neg_sel = num_sel[AccW-1] ^ nz[AccW-1];

  ris_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend({num_mag, 24'd0}), .divisor(den_mag),
    .done(div_done), .quotient(div_q)
  );

  always_comb begin
    logic [QlimW-1:0] qm;
    qm = (div_q > DivW'(64'd1 << 40)) ? QlimW'(64'd1 << 40) : div_q[QlimW-1:0];
    qs = neg_sel ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
  end

  // error saturates when either pixel difference reaches 2^28 or the shifted sum needs a 33rd bit
  assign score_err = (ovf || sq_sum[2*28]) ? '1 : sq_sum[55:24];
  assign score_inl = score_err < thresh;
  assign sum_add = {1'b0, run_sum} + {{(SumW-PixW+1){1'b0}}, score_err};

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= ThreshReset;
      run_cnt <= '0;
      run_sum <= '0;
      hyp <= '0;
      best_num <= '0;
      best_cnt <= '0;
      best_sum <= SumMax;
    end else begin
      if (cfg_we) thresh <= cfg_data;
      if (cmd.do_score && score_inl) begin
        if (run_cnt != CntMax) run_cnt <= run_cnt + 1'b1;
        run_sum <= sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
      end
      if (cmd.do_close) begin
        if (run_cnt > best_cnt || (run_cnt == best_cnt && run_sum < best_sum)) begin
          best_num <= hyp;
          best_cnt <= run_cnt;
          best_sum <= run_sum;
        end
        hyp <= (32'(hyp) + 1 >= MaxHypotheses) ? '0 : hyp + 1'b1;
        run_cnt <= '0;
        run_sum <= '0;
      end
      if (cmd.do_clear) begin
        run_cnt <= '0;
        run_sum <= '0;
        hyp <= '0;
        best_num <= '0;
        best_cnt <= '0;
        best_sum <= SumMax;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind <= in_kind;
      {wval, widx} <= in_pose[InW-1:2];
      {pt[2], pt[1], pt[0], py, px} <= in_feat;
    end
    if (cmd.do_load && widx < 4'd12) pose[widx] <= wval;
    if (cmd.do_sub) begin
      for (int i = 0; i < 3; i++)
        t[i] <= {pt[i][WordW-1], pt[i]} - {pose[9+i][WordW-1], pose[9+i]};
    end
    // t * r built from four partial products, one per cycle
    if (cmd.do_mul) begin
      for (int i = 0; i < 3; i++) begin
        logic [WordW-1:0] rw;
        logic signed [25:0] ma;
        logic signed [24:0] mb;
        logic signed [50:0] pp;
        logic signed [ProdW:0] pw;
        rw = pose[i*3 + 32'(cmd.mul_step)];
        ma = cmd.mul_part[0] ? 26'($signed(t[i][WordW:25])) : {1'b0, t[i][24:0]};
        mb = cmd.mul_part[1] ? 25'($signed(rw[WordW-1:24])) : {1'b0, rw[23:0]};
        pp = ma * mb;
        pw = (ProdW+1)'(pp);
        case (cmd.mul_part)
          2'd0: prod[i] <= pw;
          2'd1: prod[i] <= prod[i] + (pw <<< 25);
          2'd2: prod[i] <= prod[i] + (pw <<< 24);
          default: prod[i] <= prod[i] + (pw <<< 49);
        endcase
      end
    end
    if (cmd.clr_acc) begin
      nx <= '0; ny <= '0; nz <= '0;
    end else if (cmd.do_acc) begin
      logic signed [AccW-1:0] s;
      s = AccW'(prod[0]) + AccW'(prod[1]) + AccW'(prod[2]);
      case (cmd.mul_step)
        2'd0: nx <= s;
        2'd1: ny <= s;
        default: nz <= s;
      endcase
    end
    if (cmd.take_x) qx <= qs;
    if (cmd.take_y) qy <= qs;
    if (cmd.do_err) begin
      logic signed [QlimW+1:0] ex, ey;
      ex = (QlimW+2)'(qx) - (QlimW+2)'($signed(px));
      ey = (QlimW+2)'(qy) - (QlimW+2)'($signed(py));
      ux <= ex[QlimW+1] ? (QlimW+2)'(-ex) : ex;
      uy <= ey[QlimW+1] ? (QlimW+2)'(-ey) : ey;
    end
    if (cmd.do_sq) begin
      ovf <= (ux >= (QlimW+2)'(1 << 28)) || (uy >= (QlimW+2)'(1 << 28));
      sq_sum <= 57'(ux[27:0] * ux[27:0]) + 57'(uy[27:0] * uy[27:0]);
    end
    if (cmd.zero_score) begin
      err <= '1; zd <= 1'b1; inl <= 1'b0;
    end else if (cmd.do_err) begin
      zd <= 1'b0;
    end else if (cmd.do_score) begin
      err <= score_err;
      inl <= score_inl;
    end else if (cmd.load_item) begin
      err <= '0; zd <= 1'b0; inl <= 1'b0;
    end
  end

  // result fields and sums are final before out_load
  always_ff @(posedge clk) begin
    if (cmd.out_load)
      out_data <= {best_sum, best_cnt, best_num, run_sum, run_cnt, zd, inl, err};
  end
endmodule

[hdl/ris_controller.sv]
// ris_controller: sequencer for load, feature, close and clear items
// depends on ris_pkg
module ris_controller (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output ris_pkg::cmd_t cmd,
  input  ris_pkg::status_t status
);
  import ris_pkg::*;
  state_t state, state_next;
  logic [1:0] step, step_next;
  logic [1:0] part, part_next;
  logic ovalid, ovalid_next;

  assign out_valid = ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      part <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      part <= part_next;
      ovalid <= ovalid_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next = step;
    part_next = part;
    ovalid_next = ovalid && !out_ready;
    cmd = '0;
    cmd.mul_step = step;
    cmd.mul_part = part;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = ST_CHECK;
          step_next = '0;
          part_next = '0;
        end
      end
      ST_CHECK: begin
        case (kind_t'(status.kind))
          KIND_LOAD: begin cmd.do_load = 1'b1; state_next = ST_OUT; end
          KIND_CLOSE: begin cmd.do_close = 1'b1; state_next = ST_OUT; end
          KIND_CLEAR: begin cmd.do_clear = 1'b1; state_next = ST_OUT; end
          default: begin cmd.do_sub = 1'b1; cmd.clr_acc = 1'b1; state_next = ST_MUL; end
        endcase
      end
      ST_MUL: begin
        cmd.do_mul = 1'b1;
        if (part == 2'd3) begin
          part_next = '0;
          state_next = ST_ACC;
        end else begin
          part_next = part + 2'd1;
        end
      end
      ST_ACC: begin
        cmd.do_acc = 1'b1;
        if (step == 2'd2) begin
          state_next = ST_SUB;
        end else begin
          step_next = step + 2'd1;
          state_next = ST_MUL;
        end
      end
      ST_SUB: begin
        if (status.depth_zero) begin
          cmd.zero_score = 1'b1;
          state_next = ST_OUT;
        end else begin
          state_next = ST_DIVX_START;
        end
      end
      ST_DIVX_START: begin
        cmd.div_start = 1'b1;
        state_next = ST_DIVX_WAIT;
      end
      ST_DIVX_WAIT: begin
        if (status.div_done) begin
          cmd.take_x = 1'b1;
          state_next = ST_DIVY_START;
        end
      end
      ST_DIVY_START: begin
        cmd.div_sel_y = 1'b1;
        cmd.div_start = 1'b1;
        state_next = ST_DIVY_WAIT;
      end
      ST_DIVY_WAIT: begin
        cmd.div_sel_y = 1'b1;
        if (status.div_done) begin
          cmd.take_y = 1'b1;
          state_next = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.do_err = 1'b1;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.do_sq = 1'b1;
        state_next = ST_SCORE;
      end
      ST_SCORE: begin
        cmd.do_score = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid || out_ready) begin
          cmd.out_load = 1'b1;
          ovalid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

[hdl/ransac_inlier_scoring_unit.sv]
// ransac_inlier_scoring_unit: scores pose hypotheses by reprojection error
// sequence: load, close and clear items go from the check state to the output state;
// a feature item with nonzero depth also goes through multiply, accumulate, both divider
// passes, error, square and score; one item at a time, and the output state waits while a
// result is still held; the next item is taken once the result register is loaded
// reset: synchronous active-high rst clears sums, counters and best values, threshold 1678
module ransac_inlier_scoring_unit (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata from lsb: word_index(4) word_value(48) pixel_x(32) pixel_y(32)
  // point_x(48) point_y(48) point_z(48), zero padded to 264 bits
  input  logic [263:0] s_axis_tdata,
  // tuser: kind(2)
  input  logic [1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata from lsb: squared_error(32) is_inlier(1) zero_depth(1) inlier_count(13)
  // total_error(44) best_hypothesis(4) best_inliers(13) best_error(44)
  output logic [151:0] m_axis_tdata,
  input  logic cfg_we,
  input  logic [31:0] cfg_data
);
  import ris_pkg::*;
  cmd_t cmd;
  status_t status;
  logic [151:0] out_data;

  // controller: sequences each transfer through the datapath
  ris_controller u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd(cmd), .status(status)
  );

  // datapath: pose store, projection, divider, scoring, output register
  ris_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_pose({s_axis_tdata[51:0], s_axis_tuser}),
    .in_feat(s_axis_tdata[259:52]),
    .in_kind(s_axis_tuser),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .out_data(out_data)
  );

  assign m_axis_tdata = out_data;
endmodule
